### hw/rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the sensor request responder: the input and
// reply item structs, the controller/datapath command and status groups and
// the reply packet layout.
// ----------------------------------------------------------------------------
package srr_pkg;

  // sensor store and reply packet layout
  localparam int NUM_SENSORS = 13;
  localparam int ENTRY_W     = 4;
  localparam int REPLY_LEN   = 32;
  localparam int POS_W       = 5;

  localparam logic [POS_W-1:0]   REPLY_LAST = POS_W'(REPLY_LEN - 1);
  localparam logic [ENTRY_W-1:0] ENTRY_END  = ENTRY_W'(NUM_SENSORS);

  // protocol bytes
  localparam logic [7:0] REQ_OPCODE = 8'h01;
  localparam logic [7:0] START_BYTE = 8'hAA;

  // item kinds
  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // one input item
  typedef struct packed {
    logic        command;
    logic [7:0]  rx_byte;
    logic [3:0]  sensor_index;
    logic [31:0] sensor_value;
  } srr_in_t;

  // one reply item
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } srr_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic load;
  } srr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_good;
    logic out_free;
    logic at_last;
  } srr_stat_t;

  // index of the last byte sent for a store entry (entries 3 and 12 send 4)
  function automatic logic [1:0] entry_last_byte(input logic [ENTRY_W-1:0] idx);
    logic [1:0] r;
    unique case (idx)
      ENTRY_W'(3), ENTRY_W'(12): r = 2'd3;
      default:                   r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/sensor_request_responder.sv
// ----------------------------------------------------------------------------
// sensor_request_responder
// Answers two-byte serial request frames with a 32-byte sensor reply packet
// built from a store of 13 sensor words.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): each item is either a received
//   serial byte (command 0) or a write of one word into the sensor store
//   (command 1). Items are taken one per cycle while no reply is being sent.
//   reply channel (reply_valid/reply_ready/reply): one packet byte per item,
//   last_byte marks the checksum byte at the end of the 32-byte packet.
//   After the check byte of a good frame is accepted, the controller enters
//   its send state and loads the reply bytes into the output register. Reply
//   bytes go out one per cycle while the receiver is ready. Bytes are read
//   from the store one per cycle by the controller-driven cursor while the
//   receiver is ready, and the item channel is held off until the last byte
//   has been loaded.
//   A stalled receiver holds the output register and pauses the cursor.
//   Reset clears the frame state, zeroes all 13 store words and drops any
//   reply in progress.
// ----------------------------------------------------------------------------
module sensor_request_responder (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  srr_pkg::srr_in_t  item,
  output logic              reply_valid,
  input  logic              reply_ready,
  output srr_pkg::srr_out_t reply
);
  import srr_pkg::*;

  srr_cmd_t  cmd;
  srr_stat_t stat;

  // sequencing
  srr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // store, frame state and reply generation
  srr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .reply_valid (reply_valid),
    .reply_ready (reply_ready),
    .reply       (reply)
  );

endmodule

### hw/rtl/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl
// Controller: takes items while idle and sequences the 32 reply bytes into
// the datapath output register once a good request frame arrives.
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  srr_pkg::srr_stat_t stat,
  output srr_pkg::srr_cmd_t  cmd
);
  import srr_pkg::*;

  typedef enum logic [0:0] {S_IDLE, S_SEND} state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid && stat.frame_good) state <= S_SEND;
        end
        S_SEND: begin
          if (stat.out_free && stat.at_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // commands
  always_comb begin
    item_ready = (state == S_IDLE);
    cmd.accept = item_valid && (state == S_IDLE);
    cmd.start  = item_valid && (state == S_IDLE) && stat.frame_good;
    cmd.load   = (state == S_SEND) && stat.out_free;
  end

endmodule

### hw/rtl/srr_datapath.sv
// ----------------------------------------------------------------------------
// srr_datapath
// Datapath: frame tracking, the 13-word sensor store, the reply byte cursor
// and checksum, and the reply output register.
// ----------------------------------------------------------------------------
module srr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  srr_pkg::srr_in_t   item,
  input  srr_pkg::srr_cmd_t  cmd,
  output srr_pkg::srr_stat_t stat,
  output logic               reply_valid,
  input  logic               reply_ready,
  output srr_pkg::srr_out_t  reply
);
  import srr_pkg::*;

  logic               frame_count;
  logic [7:0]         frame_sum;
  logic [7:0]         frame_opcode;
  logic [31:0]        sensor_store [NUM_SENSORS];
  logic [POS_W-1:0]   pos;
  logic [ENTRY_W-1:0] entry;
  logic [1:0]         byte_idx;
  logic [7:0]         csum;
  logic [31:0]        cur_word;
  logic [7:0]         cur_byte;

  // status to the controller
  always_comb begin
    stat.frame_good = (item.command == CMD_RX_BYTE) && frame_count &&
                      (item.rx_byte == frame_sum) && (frame_opcode == REQ_OPCODE);
    stat.out_free   = !reply_valid || reply_ready;
    stat.at_last    = (pos == REPLY_LAST);
  end

  // frame tracking and store writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= 1'b0;
      frame_sum    <= '0;
      frame_opcode <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) sensor_store[i] <= '0;
    end else if (cmd.accept) begin
      if (item.command == CMD_LOAD) begin
        if (item.sensor_index < ENTRY_END) sensor_store[item.sensor_index] <= item.sensor_value;
      end else if (!frame_count) begin
        if (item.rx_byte == REQ_OPCODE) begin
          frame_opcode <= item.rx_byte;
          frame_sum    <= item.rx_byte;
          frame_count  <= 1'b1;
        end
      end else begin
        frame_count <= 1'b0;
      end
    end
  end

  // byte selection for the current reply position
  always_comb begin
    cur_word = (entry < ENTRY_END) ? sensor_store[entry] : '0;
    unique case (byte_idx)
      2'd0:    cur_byte = cur_word[7:0];
      2'd1:    cur_byte = cur_word[15:8];
      2'd2:    cur_byte = cur_word[23:16];
      default: cur_byte = cur_word[31:24];
    endcase
    if (pos == '0) begin
      cur_byte = START_BYTE;
    end else if (pos == REPLY_LAST) begin
      cur_byte = csum;
    end
  end

  // reply cursor and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      entry    <= '0;
      byte_idx <= '0;
      csum     <= '0;
    end else if (cmd.start) begin
      pos      <= '0;
      entry    <= '0;
      byte_idx <= '0;
      csum     <= '0;
    end else if (cmd.load) begin
      pos  <= pos + POS_W'(1);
      csum <= csum + cur_byte;
      if (pos != '0) begin
        if (byte_idx == entry_last_byte(entry)) begin
          entry    <= entry + ENTRY_W'(1);
          byte_idx <= '0;
        end else begin
          byte_idx <= byte_idx + 2'd1;
        end
      end
    end
  end

  // reply output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (cmd.load) begin
      reply_valid <= 1'b1;
    end else if (reply_ready) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reply.tx_byte   <= cur_byte;
      reply.last_byte <= (pos == REPLY_LAST);
    end
  end

`ifndef SYNTHESIS
  // a load never overwrites a reply byte still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!reply_valid || reply_ready))
    else $error("reply byte overwritten");

  // the first byte of a reply is the start byte
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && pos == '0) |=> (reply.tx_byte == START_BYTE && !reply.last_byte))
    else $error("reply does not open with start byte");

  // every store byte has been sent when the checksum goes out
  a_cursor_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && pos == REPLY_LAST) |-> (entry == ENTRY_END && byte_idx == 2'd0))
    else $error("reply cursor out of step with checksum");
`endif

endmodule
